// ----- rtl/aesctr_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-128 counter-mode keystream package
// Shared types, register addresses and AES byte functions.
// ----------------------------------------------------------------------------
package aesctr_pkg;

	localparam int MaxBlocks = 64;
	localparam int MaxBytes  = MaxBlocks * 16;
	localparam int AddrW     = 5;

	typedef enum logic [1:0] {
		OP_GEN   = 2'd0,
		OP_RESET = 2'd1
	} op_code_t;

	localparam logic [AddrW-1:0] ADDR_SEED_LOW   = 5'h00;
	localparam logic [AddrW-1:0] ADDR_SEED_HIGH  = 5'h08;
	localparam logic [AddrW-1:0] ADDR_NONCE      = 5'h10;
	localparam logic [AddrW-1:0] ADDR_START      = 5'h18;

	typedef struct packed {
		logic        op;
		logic [10:0] byte_count;
	} in_item_t;

	typedef struct packed {
		logic [63:0] stream_low;
		logic [63:0] stream_high;
		logic [4:0]  valid_bytes;
		logic        last;
	} out_item_t;

	// Command passed from the front end to the cipher engine.
	typedef struct packed {
		logic       rekey;
		logic [6:0] nblk;
		logic [4:0] tail;
	} cmd_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[x];
	endfunction

	// Next round key from the current round key and round constant.
	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[31:0]; w1 = k[63:32]; w2 = k[95:64]; w3 = k[127:96];
		t = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]), sbox(w3[15:8]) ^ rc};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		key_next = {w3, w2, w1, w0};
	endfunction

	// One AES round; state byte i sits at bits [8i+7:8i].
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
		logic [7:0] b [16];
		logic [7:0] m [16];
		logic [7:0] a0, a1, a2, a3;
		for (int i = 0; i < 16; i++) begin
			b[i] = sbox(s[8*i +: 8]);
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				m[r + 4*c] = b[r + 4*((c + r) & 3)];
			end
		end
		if (!final_rnd) begin
			for (int c = 0; c < 4; c++) begin
				a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
				m[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
				m[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
				m[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
				m[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
			end
		end
		for (int i = 0; i < 16; i++) begin
			aes_round[8*i +: 8] = m[i];
		end
	endfunction

endpackage

// ----- rtl/aesctr_front.sv -----
// ----------------------------------------------------------------------------
// AES-CTR front end
// Takes requests, sizes them in blocks and queues commands for the engine.
// ----------------------------------------------------------------------------
module aesctr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  aesctr_pkg::in_item_t in_item,
	output logic                cmd_valid,
	input  logic                cmd_take,
	output aesctr_pkg::cmd_t    cmd
);

	aesctr_pkg::cmd_t cmd_q [2];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic [10:0] n_sat;
	logic        keep;
	logic        acc, deq;
	aesctr_pkg::cmd_t new_cmd;

	always_comb begin
		n_sat = (in_item.byte_count > 11'(aesctr_pkg::MaxBytes)) ?
			11'(aesctr_pkg::MaxBytes) : in_item.byte_count;
		new_cmd.rekey = in_item.op;
		new_cmd.nblk  = 7'((n_sat + 11'd15) >> 4);
		new_cmd.tail  = (n_sat[3:0] == 4'd0) ? 5'd16 : {1'b0, n_sat[3:0]};
		// A zero-byte generate request leaves no trace.
		keep = in_item.op || (n_sat != 11'd0);
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = cmd_q[rd_q];
	assign acc       = push && !full && keep;
	assign deq       = cmd_valid && cmd_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (acc) begin
				wr_q <= !wr_q;
			end
			if (deq) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(acc) - 2'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q[wr_q] <= new_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !acc) else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_valid |-> !deq) else $error("command queue underflow");
	a_count_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("command count out of range");

endmodule

// ----- rtl/aesctr_engine.sv -----
// ----------------------------------------------------------------------------
// AES-CTR cipher engine
// Iterative AES-128 with on-the-fly key schedule and a one-entry result slot.
// ----------------------------------------------------------------------------
module aesctr_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_take,
	input  aesctr_pkg::cmd_t     cmd,
	input  logic [127:0]         seed,
	input  logic [63:0]          nonce,
	input  logic [63:0]          start,
	output logic                 empty,
	input  logic                 pop,
	output aesctr_pkg::out_item_t out_item
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} state_t;

	state_t       state_q;
	logic [127:0] key0_q, rk_q, st_q;
	logic [7:0]   rc_q;
	logic [3:0]   rnd_q;
	logic [63:0]  ctr_q;
	logic [6:0]   left_q;
	logic [4:0]   tail_q;
	logic         full_q;
	aesctr_pkg::out_item_t res_q;
	logic [127:0] nk;
	logic         slot_free;
	logic         load_res;

	assign nk        = aesctr_pkg::key_next(rk_q, rc_q);
	assign empty     = !full_q;
	assign out_item  = res_q;
	assign slot_free = !full_q || pop;
	assign load_res  = (state_q == S_WAIT) && slot_free;
	assign cmd_take  = (state_q == S_IDLE) && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			key0_q  <= '0;
			ctr_q   <= '0;
			full_q  <= 1'b0;
			rnd_q   <= '0;
			left_q  <= '0;
			tail_q  <= '0;
			rc_q    <= 8'h01;
		end else begin
			full_q <= load_res || (full_q && !pop);
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.rekey) begin
							key0_q <= seed;
							ctr_q  <= start;
						end else begin
							left_q  <= cmd.nblk;
							tail_q  <= cmd.tail;
							rk_q    <= key0_q;
							rc_q    <= 8'h01;
							st_q    <= {nonce, ctr_q} ^ key0_q;
							rnd_q   <= 4'd1;
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					st_q  <= aesctr_pkg::aes_round(st_q, rnd_q == 4'd10) ^ nk;
					rk_q  <= nk;
					rc_q  <= aesctr_pkg::xt(rc_q);
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == 4'd10) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (slot_free) begin
						res_q.stream_low  <= st_q[63:0];
						res_q.stream_high <= st_q[127:64];
						res_q.last        <= (left_q == 7'd1);
						res_q.valid_bytes <= (left_q == 7'd1) ? tail_q : 5'd16;
						ctr_q  <= ctr_q + 64'd1;
						left_q <= left_q - 7'd1;
						if (left_q == 7'd1) begin
							state_q <= S_IDLE;
						end else begin
							rk_q    <= key0_q;
							rc_q    <= 8'h01;
							st_q    <= {nonce, ctr_q + 64'd1} ^ key0_q;
							rnd_q   <= 4'd1;
							state_q <= S_RUN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (rnd_q >= 4'd1 && rnd_q <= 4'd10)) else $error("round out of range");
	a_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (left_q != 7'd0)) else $error("no blocks left while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q && !pop) |=> $stable(res_q)) else $error("result changed while held");

endmodule

// ----- rtl/aes128_counter_mode_keystream.sv -----
// ----------------------------------------------------------------------------
// AES-128 counter-mode keystream generator
// Queue-style request and result channels with an APB register port.
// ----------------------------------------------------------------------------
// A request is transferred when push is high and full is low. A generate
// request (op 0) for N bytes yields ceil(N/16) keystream blocks, N saturated
// to 1024; zero bytes yield nothing. A reset request (op 1) loads the key from
// seed_low/seed_high and the counter from start_count, and yields nothing.
// Results wait while empty is low and are transferred when pop is high.
// The front end queues up to two commands, so requests keep being taken while
// the cipher engine is busy. The idle engine takes the oldest queued command
// and runs the ten AES rounds of each block in turn, then hands the block off,
// loading the next block of the same request during the hand-off. Later
// blocks follow while the receiver keeps up; the round keys are computed
// alongside the rounds by the iterative round unit.
// A finished block waits in the engine until the result slot is free, so a
// stalled receiver halts the engine and then, after two commands, the input.
// Reset clears all control state; the registers, key and counter reset to 0.
// Seed and start count writes take effect at the next reset request; the
// nonce is used by every block loaded after it is written.
// ----------------------------------------------------------------------------
module aes128_counter_mode_keystream (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  aesctr_pkg::in_item_t  in_item,
	output logic                  empty,
	input  logic                  pop,
	output aesctr_pkg::out_item_t out_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [aesctr_pkg::AddrW-1:0] paddr,
	input  logic [63:0]           pwdata,
	output logic [63:0]           prdata,
	output logic                  pready
);

	logic [63:0] seed_low_q, seed_high_q, nonce_q, start_q;
	logic             cmd_valid, cmd_take;
	aesctr_pkg::cmd_t cmd;

	assign pready = 1'b1;

	// Register file: written in the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q  <= '0;
			seed_high_q <= '0;
			nonce_q     <= '0;
			start_q     <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				aesctr_pkg::ADDR_SEED_LOW:  seed_low_q  <= pwdata;
				aesctr_pkg::ADDR_SEED_HIGH: seed_high_q <= pwdata;
				aesctr_pkg::ADDR_NONCE:     nonce_q     <= pwdata;
				aesctr_pkg::ADDR_START:     start_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			aesctr_pkg::ADDR_SEED_LOW:  prdata = seed_low_q;
			aesctr_pkg::ADDR_SEED_HIGH: prdata = seed_high_q;
			aesctr_pkg::ADDR_NONCE:     prdata = nonce_q;
			aesctr_pkg::ADDR_START:     prdata = start_q;
			default:                    prdata = '0;
		endcase
	end

	aesctr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	aesctr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd),
		.seed      ({seed_high_q, seed_low_q}),
		.nonce     (nonce_q),
		.start     (start_q),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule
